// ----- sv/oal_pkg.sv -----
// ----------------------------------------------------------------------------
// oal_pkg - shared types and constants of the ordered array list
// Transaction structs, opcode and status codes, and the cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package oal_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OPCODE_W   = 2;
    localparam int POSITION_W = 5;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int INDEX_W    = 4;
    localparam int COUNT_W    = 5;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [POSITION_W-1:0] position;
        logic [VALUE_W-1:0]    value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  found_index;
        logic [COUNT_W-1:0]  count;
    } rsp_t;

    // What one cell does in a cycle.
    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,   // keep word and hit flag
        CELL_PREV = 3'd1,   // take the word of the lower neighbor
        CELL_NEXT = 3'd2,   // take the word of the upper neighbor
        CELL_LOAD = 3'd3,   // take the broadcast word
        CELL_CMP  = 3'd4,   // load hit flag from compare with broadcast word
        CELL_SCAN = 3'd5    // take the hit flag of the upper neighbor
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     live;     // cell holds a list entry
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/oal_cell.sv -----
// ----------------------------------------------------------------------------
// oal_cell - one storage cell of the ordered array list
// Holds one word and one search hit flag; moves data to and from neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_cell #(
    parameter int DATA_WIDTH = oal_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire oal_pkg::cell_ctrl_t   ctrl,
    input  wire logic [DATA_WIDTH-1:0] word,
    input  wire logic [DATA_WIDTH-1:0] prev_entry,
    input  wire logic [DATA_WIDTH-1:0] next_entry,
    input  wire logic                  next_hit,
    output logic      [DATA_WIDTH-1:0] entry,
    output logic                       hit
);
    import oal_pkg::*;

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  hit_reg;
    logic                  hit_next;

    always_comb
    begin
        entry_next = entry_reg;
        hit_next   = hit_reg;
        unique case (ctrl.op)
            CELL_HOLD: ;
            CELL_PREV: entry_next = prev_entry;
            CELL_NEXT: entry_next = next_entry;
            CELL_LOAD: entry_next = word;
            CELL_CMP:  hit_next   = ctrl.live && (entry_reg == word);
            CELL_SCAN: hit_next   = next_hit;
            default:   ;
        endcase
    end

    // Payload word needs no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

// ----- sv/ordered_array_list_core.sv -----
// ----------------------------------------------------------------------------
// ordered_array_list_core - bounded positional list of DEPTH words
// Insert, delete and find on a list held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. cmd carries opcode, 1-based position and value.
//   Response channel: done is high for exactly one cycle while rsp carries
//   status, found_index and the entry count after the operation. The
//   receiver cannot stall; a response must be taken in the cycle it shows.
// Operation and throughput:
//   Insert, delete and the unused opcode finish without a stall: cells
//   shift at once, the response shows in the cycle after acceptance and
//   busy stays low, so one such command can be taken every cycle.
//   Find compares all cells at once, then shifts the hit flags down
//   the cell row one place a cycle while a counter follows them. It keeps
//   busy high until the first match reaches cell 0 or the counter reaches
//   the count; the response shows as busy drops.
// Reset:
//   The count clears to zero and the block is idle. Cell words are not
//   cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_list_core #(
    parameter int DEPTH      = oal_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = oal_pkg::DATA_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire oal_pkg::cmd_t cmd,
    output logic               done,
    output oal_pkg::rsp_t      rsp
);
    import oal_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);   // count and scan index width
    localparam int EW = CW + 6;              // room to compare position and count

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   scan_idx_reg;
    logic [CW-1:0]   scan_idx_next;
    logic            done_reg;
    logic            done_next;
    rsp_t            rsp_reg;
    rsp_t            rsp_next;

    logic                    accept;
    logic [DATA_WIDTH-1:0]   word;
    logic [DATA_WIDTH+31:0]  word_wide;
    logic [EW-1:0]           pos_e;
    logic [EW-1:0]           pos_m1;
    logic [EW-1:0]           cnt_e;
    logic                    is_full;
    logic                    is_empty;
    logic                    ins_ok;
    logic                    del_ok;
    logic [CW+4:0]           count_out_wide;
    logic [CW+3:0]           idx_out_wide;

    cell_ctrl_t              ctrl [DEPTH];
    logic [DATA_WIDTH-1:0]   entry_w [DEPTH];
    logic                    hit_w [DEPTH];

    assign busy   = (state_reg == ST_SCAN);
    assign accept = start && !busy;

    // Use the low DATA_WIDTH bits of value, zero-extended when wider.
    assign word_wide = {{DATA_WIDTH{1'b0}}, cmd.value};
    assign word      = word_wide[DATA_WIDTH-1:0];

    assign pos_e    = {{(EW-POSITION_W){1'b0}}, cmd.position};
    assign pos_m1   = pos_e - EW'(1);
    assign cnt_e    = {{(EW-CW){1'b0}}, count_reg};
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign ins_ok   = !is_full && (pos_e != '0) && (pos_e <= cnt_e + EW'(1));
    assign del_ok   = !is_empty && (pos_e != '0) && (pos_e <= cnt_e);

    // Per-cell control: shift from the position up, load, compare or scan.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ctrl[i].live = (CW'(i) < count_reg);
            ctrl[i].op   = CELL_HOLD;
            if (accept && cmd.opcode == OP_INSERT && ins_ok)
            begin
                if (EW'(i) > pos_m1)
                begin
                    ctrl[i].op = CELL_PREV;
                end
                else if (EW'(i) == pos_m1)
                begin
                    ctrl[i].op = CELL_LOAD;
                end
            end
            else if (accept && cmd.opcode == OP_DELETE && del_ok)
            begin
                if (EW'(i) >= pos_m1)
                begin
                    ctrl[i].op = CELL_NEXT;
                end
            end
            else if (accept && cmd.opcode == OP_FIND)
            begin
                ctrl[i].op = CELL_CMP;
            end
            else if (state_reg == ST_SCAN && scan_idx_reg < count_reg && !hit_w[0])
            begin
                ctrl[i].op = CELL_SCAN;
            end
        end
    end

    // Row of cells; cell 0 holds list index 0.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] prev_w;
        logic [DATA_WIDTH-1:0] next_w;
        logic                  next_hit_w;

        if (i == 0)
        begin : g_first
            assign prev_w = word;
        end
        else
        begin : g_prev
            assign prev_w = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_w     = entry_w[i];
            assign next_hit_w = 1'b0;
        end
        else
        begin : g_next
            assign next_w     = entry_w[i+1];
            assign next_hit_w = hit_w[i+1];
        end

        oal_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl[i]),
            .word       (word),
            .prev_entry (prev_w),
            .next_entry (next_w),
            .next_hit   (next_hit_w),
            .entry      (entry_w[i]),
            .hit        (hit_w[i])
        );
    end

    // Sequencer: insert, delete and the unused opcode respond at once, find walks the hits.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        count_out_wide = '0;
        idx_out_wide   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.found_index = '0;
                    rsp_next.status      = STAT_OK;
                    done_next            = 1'b1;
                    if (cmd.opcode == OP_INSERT)
                    begin
                        if (is_full)
                        begin
                            rsp_next.status = STAT_FULL;
                        end
                        else if (!ins_ok)
                        begin
                            rsp_next.status = STAT_BADPOS;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (cmd.opcode == OP_DELETE)
                    begin
                        if (is_empty)
                        begin
                            rsp_next.status = STAT_EMPTY;
                        end
                        else if (!del_ok)
                        begin
                            rsp_next.status = STAT_BADPOS;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    else if (cmd.opcode == OP_FIND)
                    begin
                        // hold the response until the scan ends
                        done_next     = 1'b0;
                        scan_idx_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg >= count_reg)
                begin
                    rsp_next.status      = STAT_NOTFOUND;
                    rsp_next.found_index = '0;
                    done_next            = 1'b1;
                    state_next           = ST_IDLE;
                end
                else if (hit_w[0])
                begin
                    idx_out_wide         = {4'b0, scan_idx_reg};
                    rsp_next.status      = STAT_OK;
                    rsp_next.found_index = idx_out_wide[INDEX_W-1:0];
                    done_next            = 1'b1;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    // advance to the next list index
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        count_out_wide = {5'b0, count_next};
        rsp_next.count = count_out_wide[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// ----- verif/tb_ordered_array_list_core.sv -----
// ----------------------------------------------------------------------------
// tb_ordered_array_list_core - self-checking bench for the ordered array list
// Drives insert, delete, find and unused-opcode commands from a planned queue and predicts
// each response with a local list image. Every response is checked field by
// field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_ordered_array_list_core;

    import oal_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
    localparam int GEN         = 0;          // list image walked while planning stimulus
    localparam int CHK         = 1;          // list image advanced on accepted commands
    localparam int RANDOM_CMDS = 1100;
    localparam int CALM_CMDS   = 150;        // closing stretch with no sender gaps
    localparam int DRAIN_EVERY = 250;        // wait for an empty pipe this often
    localparam int TAIL_CYCLES = DEPTH + 8;
    localparam int CYCLE_LIMIT = 300000;

    // Opcode 3 has no name in the package; the block treats it as a no-op.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        cmd_t c;
        logic drain_first;   // hold until every outstanding response is back
        logic calm;          // no sender gap after this transaction
    } queued_cmd_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    // Two list images: one for planning ahead, one for checking.
    logic [DATA_WIDTH-1:0] list_words [2][DEPTH];
    int                    list_fill  [2] = '{0, 0};

    queued_cmd_t pending_cmds[$];
    rsp_t        expected_rsps[$];

    logic        cmd_taken = 1'b0;
    int          idle_left = 0;
    int unsigned cycle_cnt = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned op_seen [4] = '{default: 0};
    int unsigned status_seen [8] = '{default: 0};

    ordered_array_list_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one command to a list image and return the response it causes.
    // Only entries below the fill level are read or moved, so words that were
    // never written stay out of every comparison.
    function automatic rsp_t apply_cmd(input int copy, input cmd_t c);
        rsp_t                  r;
        int                    pos;
        int                    j;
        logic [DATA_WIDTH-1:0] w;
        logic                  hit;
        r        = '0;
        r.status = STAT_OK;
        pos      = int'(c.position);
        w        = c.value[DATA_WIDTH-1:0];
        hit      = 1'b0;
        case (c.opcode)
            OP_INSERT:
            begin
                // Full is reported ahead of the position check.
                if (list_fill[copy] >= DEPTH)
                    r.status = STAT_FULL;
                else if (pos < 1 || pos > list_fill[copy] + 1)
                    r.status = STAT_BADPOS;
                else
                begin
                    for (j = list_fill[copy]; j >= pos; j--)
                        list_words[copy][j] = list_words[copy][j-1];
                    list_words[copy][pos-1] = w;
                    list_fill[copy]++;
                end
            end
            OP_DELETE:
            begin
                // Empty is reported ahead of the position check.
                if (list_fill[copy] == 0)
                    r.status = STAT_EMPTY;
                else if (pos < 1 || pos > list_fill[copy])
                    r.status = STAT_BADPOS;
                else
                begin
                    for (j = pos - 1; j + 1 < list_fill[copy]; j++)
                        list_words[copy][j] = list_words[copy][j+1];
                    list_fill[copy]--;
                end
            end
            OP_FIND:
            begin
                // Lowest matching index wins.
                for (j = 0; j < list_fill[copy]; j++)
                begin
                    if (!hit && list_words[copy][j] == w)
                    begin
                        hit           = 1'b1;
                        r.found_index = INDEX_W'(j);
                    end
                end
                if (!hit)
                    r.status = STAT_NOTFOUND;
            end
            default:
            begin
                // unused opcode: leave the list alone
            end
        endcase
        r.count = COUNT_W'(list_fill[copy]);
        return r;
    endfunction

    function automatic cmd_t build_cmd(input logic [OPCODE_W-1:0] op,
                                       input int pos,
                                       input logic [VALUE_W-1:0] val);
        cmd_t c;
        c.opcode   = op;
        c.position = POSITION_W'(pos);
        c.value    = val;
        return c;
    endfunction

    // Favor a few recurring words so that duplicates land in the list and
    // find has to pick the lowest of several matches.
    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h0001_0000;   // +1.0 in Q16.16
            4:       return 32'hFFFF_0000;   // -1.0 in Q16.16
            default: return $urandom();
        endcase
    endfunction

    // Mostly well-formed commands against the planning image; a grow phase
    // leans toward inserts and a shrink phase toward deletes, so the list
    // swings between empty and full.
    function automatic cmd_t pick_random_cmd(input logic grow);
        cmd_t c;
        int   n;
        int   roll;
        int   ins_w;
        int   del_w;
        n          = list_fill[GEN];
        ins_w      = grow ? 40 : 18;
        del_w      = grow ? 18 : 40;
        roll       = $urandom_range(0, 99);
        c.opcode   = OP_FIND;
        c.position = POSITION_W'($urandom_range(0, 31));
        c.value    = pick_word();
        if (roll < ins_w)
        begin
            c.opcode   = OP_INSERT;
            c.position = POSITION_W'($urandom_range(1, n + 1));
        end
        else if (roll < ins_w + del_w)
        begin
            c.opcode = OP_DELETE;
            if (n > 0)
                c.position = POSITION_W'($urandom_range(1, n));
        end
        else if (roll < 80)
        begin
            // search for a word that is present
            if (n > 0)
                c.value = VALUE_W'(list_words[GEN][$urandom_range(0, n - 1)]);
        end
        else if (roll < 88)
            c.value = $urandom();
        else if (roll < 93)
            c.opcode = OP_INSERT;     // position from the whole field
        else if (roll < 98)
            c.opcode = OP_DELETE;     // position from the whole field
        else
        begin
            c.opcode = OP_UNUSED;
            c.value  = $urandom();
        end
        return c;
    endfunction

    function automatic void queue_cmd(input cmd_t c, input logic drain_first,
                                      input logic calm);
        queued_cmd_t q;
        q.c           = c;
        q.drain_first = drain_first;
        q.calm        = calm;
        pending_cmds.push_back(q);
        void'(apply_cmd(GEN, c));
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present the next queued command at the falling edge once the
    // previous transaction was taken. Hold start and cmd while busy is high.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive
        queued_cmd_t nxt;
        if (rst_n && (!start || cmd_taken))
        begin
            if (idle_left > 0)
            begin
                // sender gap: drop start for this cycle
                idle_left--;
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain_first && expected_rsps.size() > 0))
            begin
                nxt = pending_cmds.pop_front();
                cmd   <= nxt.c;
                start <= 1'b1;
                // schedule a short burst of idle cycles after this one
                if (!nxt.calm && $urandom_range(0, 4) == 0)
                    idle_left = $urandom_range(1, 4);
            end
            else
                start <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge check a response against the oldest
    // expectation, then record a command accepted at this same edge. The
    // check comes first so a stray response cannot claim the expectation of
    // the transaction that is only being taken now.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : observe
        rsp_t want;
        if (!rst_n)
            cmd_taken <= 1'b0;
        else
        begin
            cmd_taken <= start && !busy;
            if (done === 1'b1)
            begin
                if (expected_rsps.size() == 0)
                begin
                    mismatch_cnt++;
                    $display("%0t: response with none expected, actual status %0d index %0d count %0d",
                             $time, rsp.status, rsp.found_index, rsp.count);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("found_index", 32'(want.found_index), 32'(rsp.found_index));
                    check_field("count", 32'(want.count), 32'(rsp.count));
                end
            end
            if (start && !busy)
            begin
                want = apply_cmd(CHK, cmd);
                expected_rsps.push_back(want);
                op_seen[cmd.opcode]++;
                status_seen[want.status]++;
            end
        end
    end

    // Guard against a hang: a missing response or a stuck busy ends up here.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: run stalled with %0d commands queued and %0d responses outstanding",
                     $time, pending_cmds.size(), expected_rsps.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus plan and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        int                 k;
        int                 n;
        int                 pos;
        int                 seg_left;
        logic               grow;
        logic [VALUE_W-1:0] val;

        // Directed: empty-list cases and positions out of range.
        queue_cmd(build_cmd(OP_DELETE, 1, '0), 1'b0, 1'b0);
        queue_cmd(build_cmd(OP_FIND, 0, '0), 1'b0, 1'b0);
        queue_cmd(build_cmd(OP_INSERT, 0, '1), 1'b0, 1'b0);
        queue_cmd(build_cmd(OP_INSERT, 2, '0), 1'b0, 1'b0);

        // Fill to the brim, inserting at the front, the end and the middle.
        for (k = 0; k < DEPTH; k++)
        begin
            n = list_fill[GEN];
            case (k % 3)
                0:       pos = 1;
                1:       pos = n + 1;
                default: pos = n / 2 + 1;
            endcase
            case (k)
                0:       val = '0;
                1:       val = '1;
                2:       val = 32'h8000_0000;
                3:       val = 32'h7FFF_FFFF;
                default: val = $urandom();
            endcase
            queue_cmd(build_cmd(OP_INSERT, pos, val), 1'b0, 1'b0);
        end

        // Full list: insert refused before the bad position is looked at,
        // then the longest find, a bad delete, deletes at both ends and the unused opcode.
        queue_cmd(build_cmd(OP_INSERT, 31, $urandom()), 1'b0, 1'b0);
        queue_cmd(build_cmd(OP_FIND, 0, VALUE_W'(list_words[GEN][DEPTH-1])), 1'b0, 1'b0);
        queue_cmd(build_cmd(OP_DELETE, DEPTH + 1, '0), 1'b0, 1'b0);
        queue_cmd(build_cmd(OP_DELETE, DEPTH, '0), 1'b0, 1'b0);
        queue_cmd(build_cmd(OP_DELETE, 1, '0), 1'b0, 1'b0);
        queue_cmd(build_cmd(OP_UNUSED, 31, '1), 1'b0, 1'b0);

        // Random part in grow and shrink phases of random length; the
        // closing stretch has neither sender gaps nor drain waits.
        grow     = 1'b1;
        seg_left = $urandom_range(30, 90);
        for (k = 0; k < RANDOM_CMDS; k++)
        begin
            if (seg_left == 0)
            begin
                grow     = !grow;
                seg_left = $urandom_range(30, 90);
            end
            seg_left--;
            queue_cmd(pick_random_cmd(grow),
                      (k % DRAIN_EVERY == 0) && (k < RANDOM_CMDS - CALM_CMDS),
                      k >= RANDOM_CMDS - CALM_CMDS);
        end

        // Hold reset, then release it away from the rising edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every command is taken and every response is back; a
        // response that never comes is caught by the cycle limit.
        while (pending_cmds.size() != 0 || start || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d transactions: %0d insert, %0d delete, %0d find, %0d unused opcode.",
                 op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
                 op_seen[OP_INSERT], op_seen[OP_DELETE], op_seen[OP_FIND], op_seen[OP_UNUSED]);
        $display("Outcomes: %0d ok, %0d full, %0d bad position, %0d empty, %0d not found; %0d mismatches.",
                 status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_BADPOS],
                 status_seen[STAT_EMPTY], status_seen[STAT_NOTFOUND], mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
